// File: rtl/core/md5_stream_hash_assert.svh
// assertion macros for the md5 stream hash block
`ifndef MD5_STREAM_HASH_ASSERT_SVH
`define MD5_STREAM_HASH_ASSERT_SVH
// implication checked on every edge out of reset
`define MD5_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication with the consequent checked in the cycle after the antecedent
`define MD5_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/md5_pkg.sv
// types, constants and step tables for the md5 stream hash
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  // buffer write source
  typedef enum logic [1:0] {WR_BYTE, WR_PAD, WR_ZERO, WR_LEN} md5_wsel_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_en;
    md5_wsel_t  wr_sel;
    logic [5:0] wr_addr;
    logic [7:0] wr_byte;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       comp_start;
    logic       chain_init;
  } md5_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] pos;
    logic       comp_busy;
  } md5_sts_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
      4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
      4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index used by step i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'((i[3:0] * 3'd5) + 4'd1);
      2'd2: g = 4'((i[3:0] * 2'd3) + 4'd5);
      default: g = 4'(i[3:0] * 3'd7);
    endcase
    return g;
  endfunction

endpackage

// File: rtl/core/md5_stream_hash.sv
// md5 stream hash top level
// Computes MD5 over a byte stream. Input beats carry data_byte, byte_valid and
// end_of_message; a beat is taken when in_valid is high and in_stall is low.
// A byte beat that does not fill a block is written to the block buffer in
// the cycle it is taken. A byte that completes a 64-byte block starts the
// compression: 64 steps, each a word read from the block memory and then
// the step add and rotate, during which in_stall stays high.
// An end beat writes padding, zeros and length one byte per cycle, with a
// compression after each of the one or two blocks it fills, and then
// presents the digest as four output beats A, B, C, D, last_word high on D.
// A stalled output beat holds; the chaining words and byte count return to
// their initial values once D is taken, and then input beats are taken again.
// Sustained rate: one byte per cycle inside a block, with input stalled for a
// compression after each full block, set by the shared step unit and its
// single memory port.
// rst_n is synchronous and active low: it sets the initial chaining words
// and clears the byte count; the block buffer needs no clearing.
// No output beat is produced for a beat without the end flag.
module md5_stream_hash
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  md5_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output md5_out_t out_data
);

  md5_cmd_t    cmd;
  md5_sts_t    sts;
  logic [31:0] ca, cb, cc, cd;

  md5_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cmd, .sts, .chain_a(ca), .chain_b(cb), .chain_c(cc), .chain_d(cd)
  );

  md5_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .chain_a(ca), .chain_b(cb), .chain_c(cc),
    .chain_d(cd)
  );

endmodule

// File: rtl/core/md5_datapath.sv
// block buffer, byte counter, chaining words and the md5 step unit
module md5_datapath
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  md5_cmd_t    cmd,
  output md5_sts_t    sts,
  output logic [31:0] chain_a,
  output logic [31:0] chain_b,
  output logic [31:0] chain_c,
  output logic [31:0] chain_d
);

  logic [31:0] mem [16];
  logic [60:0] cnt_r, cnt_nxt;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] w_r;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] bits;
  logic [7:0]  wbyte;
  logic [31:0] f, t, rot;
  logic [4:0]  s;
  logic [5:0]  lidx;

  assign bits = {cnt_r, 3'b000};
  assign lidx = cmd.wr_addr - LEN_POS;

  always_comb begin
    case (cmd.wr_sel)
      WR_BYTE: wbyte = cmd.wr_byte;
      WR_PAD:  wbyte = PAD_BYTE;
      WR_ZERO: wbyte = 8'h00;
      default: wbyte = bits[{lidx[2:0], 3'b000} +: 8];
    endcase
  end

  // bytes are written into 32-bit words little-endian
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= wbyte;
  end

  // ph 1: word fetch registered, ph 2: step applied
  always_ff @(posedge clk) begin
    w_r <= mem[md5_g(step_r)];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) cnt_nxt = '0;
    else if (cmd.cnt_inc) cnt_nxt = cnt_r + 61'd1;
  end

  always_comb begin
    case (step_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s = md5_rot(step_r);
    t = a_r + f + w_r + md5_k(step_r);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    ph_nxt = ph_r;
    step_nxt = step_r;
    case (ph_r)
      2'd0: if (cmd.comp_start) ph_nxt = 2'd1;
      2'd1: ph_nxt = 2'd2;
      2'd2: begin
        step_nxt = step_r + 6'd1;
        ph_nxt = (step_r == 6'd63) ? 2'd3 : 2'd1;
      end
      default: ph_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ph_r <= 2'd0;
      step_r <= '0;
      h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
    end else begin
      cnt_r <= cnt_nxt;
      ph_r <= ph_nxt;
      step_r <= step_nxt;
      if (cmd.chain_init) begin
        h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
      end else if (ph_r == 2'd3) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == 2'd0 && cmd.comp_start) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
    end else if (ph_r == 2'd2) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= rot + b_r;
    end
  end

  assign sts.pos = cnt_r[5:0];
  assign sts.comp_busy = (ph_r != 2'd0);
  assign chain_a = h_r[0];
  assign chain_b = h_r[1];
  assign chain_c = h_r[2];
  assign chain_d = h_r[3];

endmodule

// File: rtl/core/md5_ctrl.sv
// controller: input beats, padding sequence and digest output
module md5_ctrl
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  md5_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output md5_out_t    out_data,
  output md5_cmd_t    cmd,
  input  md5_sts_t    sts,
  input  logic [31:0] chain_a,
  input  logic [31:0] chain_b,
  input  logic [31:0] chain_c,
  input  logic [31:0] chain_d
);

  `include "md5_stream_hash_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_PAD, S_ZERO, S_LEN, S_FIN, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic        fin_r, fin_nxt;    // message end pending
  logic        two_r, two_nxt;    // extra block needed
  logic [5:0]  addr_r, addr_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] dw;
  logic        acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;

  always_comb begin
    case (idx_r)
      2'd0: dw = chain_a;
      2'd1: dw = chain_b;
      2'd2: dw = chain_c;
      default: dw = chain_d;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    two_nxt = two_r;
    addr_nxt = addr_r;
    idx_nxt = idx_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.wr_byte = in_data.data_byte;
    cmd.wr_addr = addr_r;
    cmd.wr_sel = WR_ZERO;
    unique case (state_r)
      S_IDLE: if (acc) begin
        fin_nxt = in_data.end_of_message;
        addr_nxt = sts.pos;
        if (in_data.byte_valid) begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = WR_BYTE;
          cmd.wr_addr = sts.pos;
          cmd.cnt_inc = 1'b1;
          addr_nxt = sts.pos + 6'd1;
          if (sts.pos == 6'd63) begin
            cmd.comp_start = 1'b1;
            state_nxt = S_WAIT;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end else if (in_data.end_of_message) begin
          state_nxt = S_PAD;
        end
      end
      S_WAIT: if (!sts.comp_busy) begin
        state_nxt = fin_r ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = WR_PAD;
        two_nxt = (addr_r >= LEN_POS);
        addr_nxt = addr_r + 6'd1;
        if (addr_r == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = (addr_r + 6'd1 >= LEN_POS) ? S_LEN : S_ZERO;
        end
      end
      S_ZERO: begin
        // zero fill up to the length field; in the extra-block case from the start of the second block
        cmd.wr_en = 1'b1;
        addr_nxt = addr_r + 6'd1;
        if (two_r && addr_r == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = S_FIN;
        end else if (!two_r && addr_r + 6'd1 == LEN_POS) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (two_r) begin
          cmd.wr_en = 1'b1;
          addr_nxt = addr_r + 6'd1;
          if (addr_r == 6'd63) begin
            cmd.comp_start = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = WR_LEN;
          addr_nxt = addr_r + 6'd1;
          if (addr_r == 6'd63) begin
            cmd.comp_start = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: if (!sts.comp_busy) begin
        if (two_r) begin
          two_nxt = 1'b0;
          addr_nxt = '0;
          state_nxt = S_ZERO;
        end else begin
          idx_nxt = '0;
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (!out_stall) begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          ov_nxt = 1'b0;
          cmd.chain_init = 1'b1;
          cmd.cnt_clr = 1'b1;
          fin_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      addr_r <= '0;
      idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      two_r <= two_nxt;
      addr_r <= addr_nxt;
      idx_r <= idx_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data.digest_word = dw;
  assign out_data.word_index = idx_r;
  assign out_data.last_word = (idx_r == 2'd3);

  `MD5_ASSERT_IMP(a_out_only_in_out, out_valid, state_r == S_OUT)
  `MD5_ASSERT_IMP(a_no_start_busy, cmd.comp_start, !sts.comp_busy)
  `MD5_ASSERT_NXT(a_last_leaves, out_valid && !out_stall && out_data.last_word,
    !out_valid)

endmodule
